[src/kline_pkg.sv]
// Shared constants and types for the K-line block protocol engine.
`timescale 1ns / 1ps

package kline_pkg;

  localparam int unsigned MAX_SEND_DATA = 16;
  localparam int unsigned STORE_AW = (MAX_SEND_DATA > 1) ? $clog2(MAX_SEND_DATA) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_SEND_DATA + 1);

  localparam logic [7:0] END_BYTE   = 8'h03;
  localparam logic [7:0] HEADER_LEN = 8'd3;

  localparam logic [7:0]  ACK_TITLE_RST    = 8'd9;
  localparam logic [15:0] KEEPALIVE_MS_RST = 16'd500;
  localparam logic [15:0] TIMEOUT_MS_RST   = 16'd1000;

  localparam logic [1:0] REG_ACK_TITLE    = 2'd0;
  localparam logic [1:0] REG_KEEPALIVE_MS = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_MS   = 2'd2;

  localparam logic [1:0] OP_LINE_BYTE = 2'd0;
  localparam logic [1:0] OP_LOAD      = 2'd1;
  localparam logic [1:0] OP_START     = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_LENGTH  = 3'd1;
  localparam logic [2:0] KIND_COUNTER = 3'd2;
  localparam logic [2:0] KIND_TITLE   = 3'd3;
  localparam logic [2:0] KIND_DATA    = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ECHO    = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT = 2'd2;
  localparam logic [1:0] ERR_BUSY    = 2'd3;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic [2:0] got_kind;
    logic [7:0] got_byte;
    logic [1:0] error_code;
    logic       engine_busy;
    logic [7:0] block_counter;
  } result_t;

endpackage

[src/kline_block_protocol_engine.sv]
// K-line block protocol engine, tester side: block send, echo check, answers, keepalive, timeout.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   in      | sink      | in_valid_i/in_stall_o | op_i, byte_value_i
//   out     | source    | out_valid_o/out_stall_i | send_valid_o .. block_counter_o
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; its result is registered.
// The rate is set by the combinational phase update that feeds the state and result registers.
// A two-entry output (result register plus skid) keeps input flowing under one stalled result.
// Reset idles the engine and loads the register defaults; the send store needs no clearing.
// cfg_ready_o is always high.
`timescale 1ns / 1ps

module kline_block_protocol_engine
  import kline_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_valid_o,
  output logic [7:0]  send_byte_o,
  output logic [2:0]  got_kind_o,
  output logic [7:0]  got_byte_o,
  output logic [1:0]  error_code_o,
  output logic        engine_busy_o,
  output logic [7:0]  block_counter_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_TX_LEN = 4'd1,
    PH_TX_CNT = 4'd2,
    PH_TX_TTL = 4'd3,
    PH_TX_DAT = 4'd4,
    PH_TX_END = 4'd5,
    PH_RX_LEN = 4'd6,
    PH_RX_CNT = 4'd7,
    PH_RX_TTL = 4'd8,
    PH_RX_DAT = 4'd9,
    PH_RX_END = 4'd10
  } phase_e;

  phase_e              phase_q, phase_d;
  logic                echo_wait_q, echo_wait_d;
  logic [7:0]          data_left_q, data_left_d;
  logic [7:0]          seq_q, seq_d;
  logic [7:0]          exp_echo_q, exp_echo_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [FILL_W-1:0]   pos_q, pos_d;
  logic [7:0]          title_q, title_d;
  logic [15:0]         idle_q, idle_d;
  logic [7:0]          ack_title_q;
  logic [15:0]         keepalive_q, timeout_q;
  logic [7:0]          store_q [MAX_SEND_DATA];
  logic                store_we;

  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    accept_in, out_take;

  assign in_stall_o  = skid_valid_q;
  assign cfg_ready_o = 1'b1;
  assign accept_in   = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;

  always_comb begin
    logic [7:0] b;
    logic [7:0] em_byte;
    logic       em;
    logic       idle_go;
    b          = byte_value_i;
    em         = 1'b0;
    em_byte    = 8'h00;
    idle_go    = 1'b0;
    store_we   = 1'b0;
    phase_d    = phase_q;
    echo_wait_d = echo_wait_q;
    data_left_d = data_left_q;
    seq_d      = seq_q;
    exp_echo_d = exp_echo_q;
    fill_d     = fill_q;
    pos_d      = pos_q;
    title_d    = title_q;
    idle_d     = idle_q;
    res        = '0;

    case (op_i)
      OP_LINE_BYTE: begin
        if (phase_q != PH_IDLE) begin
          idle_d = 16'd0;
          if (echo_wait_q) begin
            if (b != exp_echo_q) begin
              res.error_code = ERR_ECHO;
              idle_go = 1'b1;
            end else begin
              echo_wait_d = 1'b0;
              case (phase_q)
                PH_TX_END: phase_d = PH_RX_LEN;
                PH_RX_LEN: phase_d = PH_RX_CNT;
                PH_RX_CNT: phase_d = PH_RX_TTL;
                PH_RX_TTL, PH_RX_DAT:
                  phase_d = (data_left_q != 8'd0) ? PH_RX_DAT : PH_RX_END;
                default: ;
              endcase
            end
          end else if (phase_q <= PH_TX_DAT) begin
            em = 1'b1;
            case (phase_q)
              PH_TX_LEN: begin
                seq_d   = seq_q + 8'd1;
                phase_d = PH_TX_CNT;
                em_byte = seq_q + 8'd1;
              end
              PH_TX_CNT: begin
                phase_d = PH_TX_TTL;
                em_byte = title_q;
              end
              default: begin
                if (data_left_q != 8'd0 && pos_q < FILL_W'(MAX_SEND_DATA)) begin
                  em_byte     = store_q[pos_q[STORE_AW-1:0]];
                  pos_d       = pos_q + FILL_W'(1);
                  data_left_d = data_left_q - 8'd1;
                  phase_d     = PH_TX_DAT;
                end else begin
                  data_left_d = 8'd0;
                  phase_d     = PH_TX_END;
                  em_byte     = END_BYTE;
                end
              end
            endcase
          end else begin
            res.got_byte = b;
            em      = 1'b1;
            em_byte = ~b;
            case (phase_q)
              PH_RX_LEN: begin
                res.got_kind = KIND_LENGTH;
                data_left_d  = (b > HEADER_LEN) ? b - HEADER_LEN : 8'd0;
              end
              PH_RX_CNT: begin
                res.got_kind = KIND_COUNTER;
                if (b > seq_q) seq_d = b;
              end
              PH_RX_TTL: res.got_kind = KIND_TITLE;
              PH_RX_DAT: begin
                res.got_kind = KIND_DATA;
                if (data_left_q != 8'd0) data_left_d = data_left_q - 8'd1;
              end
              default: begin
                res.got_kind = KIND_END;
                em      = 1'b0;
                idle_go = 1'b1;
              end
            endcase
          end
        end
      end
      OP_LOAD: begin
        if (phase_q != PH_IDLE || fill_q >= FILL_W'(MAX_SEND_DATA)) begin
          res.error_code = ERR_BUSY;
        end else begin
          store_we = 1'b1;
          fill_d   = fill_q + FILL_W'(1);
        end
      end
      OP_START: begin
        if (phase_q != PH_IDLE) begin
          res.error_code = ERR_BUSY;
        end else begin
          fill_d      = '0;
          title_d     = b;
          data_left_d = 8'(fill_q);
          pos_d       = '0;
          idle_d      = 16'd0;
          phase_d     = PH_TX_LEN;
          em          = 1'b1;
          em_byte     = HEADER_LEN + 8'(fill_q);
        end
      end
      default: begin
        if (idle_q != 16'hFFFF) idle_d = idle_q + 16'd1;
        if (phase_q != PH_IDLE) begin
          if (idle_d > timeout_q) begin
            res.error_code = ERR_TIMEOUT;
            idle_go = 1'b1;
          end
        end else if (idle_d > timeout_q) begin
          res.error_code = ERR_TIMEOUT;
          idle_d = 16'd0;
        end else if (idle_d > keepalive_q) begin
          title_d     = ack_title_q;
          data_left_d = 8'd0;
          pos_d       = '0;
          idle_d      = 16'd0;
          phase_d     = PH_TX_LEN;
          em          = 1'b1;
          em_byte     = HEADER_LEN;
        end
      end
    endcase

    if (em) begin
      res.send_valid = 1'b1;
      res.send_byte  = em_byte;
      exp_echo_d     = em_byte;
      echo_wait_d    = 1'b1;
    end
    if (idle_go) begin
      phase_d     = PH_IDLE;
      echo_wait_d = 1'b0;
      data_left_d = 8'd0;
      pos_d       = '0;
      idle_d      = 16'd0;
    end
    res.engine_busy   = (phase_d != PH_IDLE);
    res.block_counter = seq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      echo_wait_q <= 1'b0;
      data_left_q <= 8'd0;
      seq_q       <= 8'd0;
      exp_echo_q  <= 8'd0;
      fill_q      <= '0;
      pos_q       <= '0;
      title_q     <= 8'd0;
      idle_q      <= 16'd0;
    end else if (accept_in) begin
      phase_q     <= phase_d;
      echo_wait_q <= echo_wait_d;
      data_left_q <= data_left_d;
      seq_q       <= seq_d;
      exp_echo_q  <= exp_echo_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      title_q     <= title_d;
      idle_q      <= idle_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_title_q <= ACK_TITLE_RST;
      keepalive_q <= KEEPALIVE_MS_RST;
      timeout_q   <= TIMEOUT_MS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ACK_TITLE:    ack_title_q <= cfg_data_i[7:0];
        REG_KEEPALIVE_MS: keepalive_q <= cfg_data_i;
        REG_TIMEOUT_MS:   timeout_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in && store_we) begin
      store_q[fill_q[STORE_AW-1:0]] <= byte_value_i;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept_in) begin
        out_q <= res;
      end
    end else if (accept_in) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign send_valid_o    = out_q.send_valid;
  assign send_byte_o     = out_q.send_byte;
  assign got_kind_o      = out_q.got_kind;
  assign got_byte_o      = out_q.got_byte;
  assign error_code_o    = out_q.error_code;
  assign engine_busy_o   = out_q.engine_busy;
  assign block_counter_o = out_q.block_counter;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while result register empty");

  a_idle_no_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (!echo_wait_q && data_left_q == 8'd0))
    else $error("idle engine still waits for an echo or holds data");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(MAX_SEND_DATA))
    else $error("send store overfilled");

  a_busy_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_in && !out_valid_q && !skid_valid_q) |=>
      (out_valid_q && out_q.engine_busy == (phase_q != PH_IDLE)))
    else $error("reported busy flag disagrees with engine phase");

  a_send_on_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_in && res.send_valid) |=> echo_wait_q)
    else $error("sent byte without awaiting its echo");

endmodule

[sim/tb.sv]
// Self-checking testbench for the K-line block protocol engine.
`timescale 1ns / 1ps

module tb
  import kline_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEND_LEN,
    ST_SEND_CNT,
    ST_SEND_TTL,
    ST_SEND_DAT,
    ST_SEND_END,
    ST_RECV_LEN,
    ST_RECV_CNT,
    ST_RECV_TTL,
    ST_RECV_DAT,
    ST_RECV_END
  } link_state_e;

  class kline_scoreboard;
    logic [7:0] ack_title;
    logic [15:0] keepalive_ms;
    logic [15:0] timeout_ms;
    link_state_e state;
    bit echo_pending;
    logic [7:0] bytes_left;
    logic [7:0] seq_count;
    logic [7:0] echo_byte;
    logic [7:0] tx_data [MAX_SEND_DATA];
    logic [4:0] tx_fill;
    logic [4:0] tx_pos;
    logic [7:0] title_hold;
    logic [15:0] idle_ms;
    result_t resp;
    result_t awaited_responses [$];
    int unsigned fail_count;

    function new();
      ack_title = ACK_TITLE_RST;
      keepalive_ms = KEEPALIVE_MS_RST;
      timeout_ms = TIMEOUT_MS_RST;
      drop_to_idle();
      seq_count = '0;
      echo_byte = '0;
      tx_fill = '0;
      title_hold = '0;
      fail_count = 0;
      foreach (tx_data[i]) tx_data[i] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_ACK_TITLE:    ack_title = value[7:0];
        REG_KEEPALIVE_MS: keepalive_ms = value;
        REG_TIMEOUT_MS:   timeout_ms = value;
        default: ;
      endcase
    endfunction

    function void drop_to_idle();
      state = ST_IDLE;
      echo_pending = 1'b0;
      bytes_left = '0;
      tx_pos = '0;
      idle_ms = '0;
    endfunction

    function void send_line(logic [7:0] b);
      resp.send_valid = 1'b1;
      resp.send_byte = b;
      echo_byte = b;
      echo_pending = 1'b1;
    endfunction

    function void open_block(logic [7:0] title, logic [7:0] count);
      title_hold = title;
      bytes_left = count;
      tx_pos = '0;
      idle_ms = '0;
      state = ST_SEND_LEN;
      send_line(HEADER_LEN + count);
    endfunction

    function void advance_send();
      logic [7:0] b;
      case (state)
        ST_SEND_LEN: begin
          seq_count = seq_count + 8'd1;
          state = ST_SEND_CNT;
          send_line(seq_count);
        end
        ST_SEND_CNT: begin
          state = ST_SEND_TTL;
          send_line(title_hold);
        end
        default: begin
          if (bytes_left != 0 && tx_pos < MAX_SEND_DATA) begin
            b = tx_data[tx_pos];
            tx_pos = tx_pos + 5'd1;
            bytes_left = bytes_left - 8'd1;
            state = ST_SEND_DAT;
            send_line(b);
          end else begin
            bytes_left = '0;
            state = ST_SEND_END;
            send_line(END_BYTE);
          end
        end
      endcase
    endfunction

    function void take_line_byte(logic [7:0] b);
      if (state == ST_IDLE) return;
      idle_ms = '0;
      if (echo_pending) begin
        if (b != echo_byte) begin
          resp.error_code = ERR_ECHO;
          drop_to_idle();
          return;
        end
        echo_pending = 1'b0;
        case (state)
          ST_SEND_END: state = ST_RECV_LEN;
          ST_RECV_LEN: state = ST_RECV_CNT;
          ST_RECV_CNT: state = ST_RECV_TTL;
          ST_RECV_TTL, ST_RECV_DAT: state = (bytes_left != 0) ? ST_RECV_DAT : ST_RECV_END;
          default: ;
        endcase
        return;
      end
      if (state <= ST_SEND_DAT) begin
        advance_send();
        return;
      end
      resp.got_byte = b;
      case (state)
        ST_RECV_LEN: begin
          resp.got_kind = KIND_LENGTH;
          bytes_left = (b > HEADER_LEN) ? b - HEADER_LEN : 8'd0;
        end
        ST_RECV_CNT: begin
          resp.got_kind = KIND_COUNTER;
          if (b > seq_count) seq_count = b;
        end
        ST_RECV_TTL: resp.got_kind = KIND_TITLE;
        ST_RECV_DAT: begin
          resp.got_kind = KIND_DATA;
          if (bytes_left != 0) bytes_left = bytes_left - 8'd1;
        end
        default: begin
          resp.got_kind = KIND_END;
          drop_to_idle();
          return;
        end
      endcase
      send_line(~b);
    endfunction

    function result_t predict_response(logic [1:0] op, logic [7:0] b);
      logic [7:0] n;
      resp = '0;
      case (op)
        OP_LINE_BYTE: take_line_byte(b);
        OP_LOAD: begin
          if (state != ST_IDLE || tx_fill >= MAX_SEND_DATA) begin
            resp.error_code = ERR_BUSY;
          end else begin
            tx_data[tx_fill] = b;
            tx_fill = tx_fill + 5'd1;
          end
        end
        OP_START: begin
          if (state != ST_IDLE) begin
            resp.error_code = ERR_BUSY;
          end else begin
            n = 8'(tx_fill);
            tx_fill = '0;
            open_block(b, n);
          end
        end
        default: begin
          if (idle_ms != 16'hFFFF) idle_ms = idle_ms + 16'd1;
          if (state != ST_IDLE) begin
            if (idle_ms > timeout_ms) begin
              resp.error_code = ERR_TIMEOUT;
              drop_to_idle();
            end
          end else if (idle_ms > timeout_ms) begin
            resp.error_code = ERR_TIMEOUT;
            idle_ms = '0;
          end else if (idle_ms > keepalive_ms) begin
            open_block(ack_title, 8'd0);
          end
        end
      endcase
      resp.engine_busy = (state != ST_IDLE);
      resp.block_counter = seq_count;
      return resp;
    endfunction

    function void note_item(logic [1:0] op, logic [7:0] b);
      awaited_responses = {awaited_responses, predict_response(op, b)};
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        if (fail_count < MAX_REPORTS)
          $error("%s: expected %0h, got %0h", name, want, seen);
        fail_count++;
      end
    endfunction

    function void check_result(result_t seen);
      result_t want;
      if (awaited_responses.size() == 0) begin
        if (fail_count < MAX_REPORTS) $error("result with no item pending");
        fail_count++;
        return;
      end
      want = awaited_responses.pop_front();
      compare_field("send_valid", 8'(want.send_valid), 8'(seen.send_valid));
      compare_field("send_byte", want.send_byte, seen.send_byte);
      compare_field("got_kind", 8'(want.got_kind), 8'(seen.got_kind));
      compare_field("got_byte", want.got_byte, seen.got_byte);
      compare_field("error_code", 8'(want.error_code), 8'(seen.error_code));
      compare_field("engine_busy", 8'(want.engine_busy), 8'(seen.engine_busy));
      compare_field("block_counter", want.block_counter, seen.block_counter);
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        item_valid = 1'b0;
  logic [1:0]  item_op = OP_TICK;
  logic [7:0]  item_byte = 8'h00;
  logic        resp_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_ACK_TITLE;
  logic [15:0] cfg_data = 16'h0000;

  logic        in_stall;
  logic        out_valid;
  logic        cfg_ready;
  logic        send_valid;
  logic [7:0]  send_byte;
  logic [2:0]  got_kind;
  logic [7:0]  got_byte;
  logic [1:0]  error_code;
  logic        engine_busy;
  logic [7:0]  block_counter;

  kline_scoreboard kline_check;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned fill_goal = 2;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_req = 1'b0;

  kline_block_protocol_engine u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (item_valid),
    .in_stall_o     (in_stall),
    .op_i           (item_op),
    .byte_value_i   (item_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (resp_stall),
    .send_valid_o   (send_valid),
    .send_byte_o    (send_byte),
    .got_kind_o     (got_kind),
    .got_byte_o     (got_byte),
    .error_code_o   (error_code),
    .engine_busy_o  (engine_busy),
    .block_counter_o(block_counter),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      resp_stall <= 1'b1;
    end else begin
      resp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (out_valid === 1'b1 && resp_stall == 1'b0)
      kline_check.check_result({send_valid, send_byte, got_kind, got_byte, error_code,
                                engine_busy, block_counter});
  end

  always @(posedge clk) begin
    if ((item_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !resp_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] b);
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    item_valid <= 1'b1;
    item_op <= op;
    item_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    kline_check.note_item(op, b);
  endtask

  task automatic release_input();
    item_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (kline_check.awaited_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] title, input logic [15:0] ka,
                            input logic [15:0] to);
    logic [1:0]  idx [3];
    logic [15:0] val [3];
    idx = '{REG_ACK_TITLE, REG_KEEPALIVE_MS, REG_TIMEOUT_MS};
    val = '{{8'h00, title}, ka, to};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      kline_check.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed exchanges, steered by the predicted engine state
  function automatic void pick_item(output logic [1:0] op, output logic [7:0] b);
    int unsigned r;
    r = $urandom_range(0, 99);
    b = 8'($urandom);
    if (r < 5) begin
      op = 2'($urandom);
    end else if (kline_check.state == ST_IDLE) begin
      if (r < 17) begin
        op = OP_TICK;
      end else if (kline_check.tx_fill < fill_goal ||
                   (kline_check.tx_fill == MAX_SEND_DATA && r < 30)) begin
        op = OP_LOAD;
      end else begin
        op = OP_START;
        r = $urandom_range(0, 99);
        fill_goal = (r < 70) ? $urandom_range(0, 4) :
                    (r < 90) ? $urandom_range(5, 15) : MAX_SEND_DATA;
      end
    end else if (r < 8) begin
      op = OP_TICK;
    end else if (r < 10) begin
      op = r[0] ? OP_LOAD : OP_START;
    end else begin
      op = OP_LINE_BYTE;
      if (kline_check.echo_pending) begin
        b = (r == 10) ? kline_check.echo_byte ^ 8'($urandom_range(1, 255))
                      : kline_check.echo_byte;
      end else begin
        r = $urandom_range(0, 99);
        case (kline_check.state)
          ST_RECV_LEN: begin
            if (r < 20) b = 8'($urandom_range(0, 3));
            else if (r < 85) b = 8'($urandom_range(4, 8));
            else if (r < 98) b = 8'($urandom_range(9, 24));
          end
          ST_RECV_CNT: begin
            if (r < 40) b = kline_check.seq_count + 8'd1;
            else if (r < 50) b = 8'hFF;
          end
          ST_RECV_TTL, ST_RECV_DAT: ;
          ST_RECV_END: if (r < 90) b = END_BYTE;
          default: if (r < 80) b = ~kline_check.echo_byte;
        endcase
      end
    end
  endfunction

  task automatic directed_items();
    send_item(OP_LINE_BYTE, 8'hAA);   // ignored while idle
    send_item(OP_LOAD, 8'hFF);
    send_item(OP_START, 8'h00);
    send_item(OP_START, 8'h11);       // busy
    send_item(OP_LOAD, 8'h22);        // busy
    repeat (4) begin                  // length, counter, title, data
      send_item(OP_LINE_BYTE, kline_check.echo_byte);
      send_item(OP_LINE_BYTE, ~kline_check.echo_byte);
    end
    send_item(OP_LINE_BYTE, kline_check.echo_byte);  // end byte, no complement
    send_item(OP_LINE_BYTE, 8'h04);   // answer with one data byte
    send_item(OP_LINE_BYTE, kline_check.echo_byte);
    send_item(OP_LINE_BYTE, 8'hFF);   // larger counter is taken
    send_item(OP_LINE_BYTE, kline_check.echo_byte);
    send_item(OP_LINE_BYTE, 8'h3C);
    send_item(OP_LINE_BYTE, kline_check.echo_byte);
    send_item(OP_LINE_BYTE, 8'h00);
    send_item(OP_LINE_BYTE, kline_check.echo_byte);
    send_item(OP_LINE_BYTE, 8'h77);   // end of answer, any value
    send_item(OP_START, 8'h01);       // counter wraps to zero
    send_item(OP_LINE_BYTE, kline_check.echo_byte);
    send_item(OP_LINE_BYTE, 8'hFC);
    send_item(OP_LINE_BYTE, ~kline_check.echo_byte);  // bad echo aborts
  endtask

  task automatic run_phase(input logic [7:0] title, input logic [15:0] ka,
                           input logic [15:0] to, input int unsigned tx_pct,
                           input int unsigned rx_pct, input int unsigned items,
                           input bit pressure);
    int unsigned n;
    int unsigned iter;
    logic [1:0] op;
    logic [7:0] b;
    release_input();
    wait_drained();
    write_regs(title, ka, to);
    sender_idle_pct = tx_pct;
    receiver_stall_pct = rx_pct;
    n = 0;
    iter = 0;
    while (n < items) begin
      if (pressure && iter == 60) hold_req = 1'b1;
      if (pressure && iter == 200) begin
        release_input();
        wait_drained();
      end
      pick_item(op, b);
      if (!(op == OP_LINE_BYTE && kline_check.state == ST_IDLE)) n++;
      iter++;
      send_item(op, b);
    end
  endtask

  initial begin
    kline_check = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();

    run_phase(8'hFF, 16'd1, 16'd2, 0, 0, 290, 1'b1);
    run_phase(8'h00, 16'd4, 16'd1, 76, 0, 290, 1'b0);
    run_phase(8'($urandom), 16'($urandom_range(2, 12)), 16'($urandom_range(6, 40)),
              0, 76, 290, 1'b0);
    run_phase(8'h5A, 16'hFFFF, 16'hFFFF, 19, 19, 290, 1'b0);

    release_input();
    wait_drained();
    repeat (8) @(posedge clk);
    if (kline_check.fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
